### rtl/bht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backend health tracker package
// Shared types and constants: the per-server table entry and the divider
// result bundle.
// ----------------------------------------------------------------------------
package bht_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;

  localparam int unsigned PCT_SCALE = 100;
  localparam logic [6:0]  PCT_MAX   = 7'd100;
  localparam int unsigned PCT_NUM_W = 39;

  typedef struct packed {
    logic        health;
    logic [7:0]  streak;
    logic [15:0] active;
    logic [31:0] req;
    logic [31:0] fails;
    logic [63:0] tsum;
    logic [31:0] avg;
    logic [6:0]  pct;
  } bht_entry_t;

  localparam bht_entry_t ENTRY_RST = '{
    health: 1'b1,
    streak: 8'd0,
    active: 16'd0,
    req:    32'd0,
    fails:  32'd0,
    tsum:   64'd0,
    avg:    32'd0,
    pct:    7'd0
  };

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic        dz;
    logic [31:0] quo;
  } bht_div_res_t;

endpackage
`default_nettype wire

### rtl/bht_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Divides a 64-bit dividend by a 32-bit divisor one quotient bit per cycle.
// Flags a zero divisor and a quotient that does not fit in 32 bits.
// ----------------------------------------------------------------------------
module bht_div
  import bht_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  dividend,
  input  wire logic [31:0]  divisor,
  output bht_div_res_t      res
);

  logic [31:0] rem_r;
  logic [31:0] q_r;
  logic [31:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        ovf_r;
  logic        dz_r;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] rem_nxt;
  logic [31:0] q_nxt;

  always_comb begin
    trial   = {rem_r, q_r[31]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[31:0] : trial[31:0];
    q_nxt   = {q_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[63:32];
      q_r   <= dividend[31:0];
      dvs_r <= divisor;
      ovf_r <= (dividend[63:32] >= divisor);
      dz_r  <= (divisor == 32'd0);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.dz   = dz_r;
  assign res.quo  = q_r;

endmodule
`default_nettype wire

### rtl/backend_health_stats_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backend health statistics tracker
// Per-server and pool-wide request counters, averages and health flags.
//
// Input items carry a start, end or query event for one server; each item
// produces exactly one status item on the output channel. Items are taken
// one at a time: the server's entry is read from the table memory and
// updated, and for a start or end item in range written back, before the next
// item is accepted. A start or query item passes through the update,
// write-back and output steps. An end item for a server in range also runs
// three 32-step radix-2 dividers side by side (server average, server
// failure percent, pool average) and waits for them before write-back.
// A new item is accepted once the previous result sits in the output
// register, even while the receiver still stalls it; the next result then
// waits until that register is free.
// Reset clears the control state, the pool counters and the table valid
// bits, so every server reads as healthy with zero counts. The failure
// threshold resets to 3 and may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module backend_health_stats_tracker
  import bht_pkg::*;
#(
  parameter int NUM_SERVERS = 16
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [3:0]  in_server_index,
  input  wire logic        in_success,
  input  wire logic [31:0] in_response_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_server_id,
  output logic             out_healthy,
  output logic [15:0]      out_in_flight,
  output logic [31:0]      out_server_avg_time,
  output logic [6:0]       out_server_fail_percent,
  output logic [7:0]       out_streak,
  output logic [31:0]      out_pool_avg_time,
  output logic [31:0]      out_pool_fail_count,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  localparam int AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam logic [8:0] SC = 9'(NUM_SERVERS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIVW  = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'd0, b};
    sat_add64 = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  logic [2:0]      state_r;
  logic [2:0]      state_nxt;
  logic [7:0]      thr_r;

  logic [1:0]      op_r;
  logic [3:0]      idx_r;
  logic            ok_r;
  logic [31:0]     rt_r;
  logic            range_r;
  logic [AW-1:0]   addr_r;

  bht_entry_t      mem_r [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] vld_r;
  bht_entry_t      rd_q_r;
  logic            rd_vld_r;

  bht_entry_t      upd_r;
  bht_entry_t      cur;
  bht_entry_t      upd_nxt;
  logic [PCT_NUM_W-1:0] pctnum_r;

  logic [31:0]     pool_req_r;
  logic [31:0]     pool_fail_r;
  logic [63:0]     pool_sum_r;
  logic [31:0]     pool_avg_r;
  logic [31:0]     pool_req_nxt;
  logic [31:0]     pool_fail_nxt;
  logic [63:0]     pool_sum_nxt;

  logic [8:0]      idx_ext;
  logic [AW-1:0]   rd_addr;
  logic            in_range;
  logic            acc;
  logic            mem_we;
  logic            out_load;
  logic            div_start;
  logic [7:0]      streak_inc;

  bht_div_res_t    avg_res;
  bht_div_res_t    pct_res;
  bht_div_res_t    pool_res;

  logic [31:0]     avg_val;
  logic [6:0]      pct_val;
  logic [31:0]     pool_avg_val;

  assign idx_ext  = {5'd0, in_server_index};
  assign rd_addr  = idx_ext[AW-1:0];
  assign in_range = (idx_ext < SC);
  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign div_start = (state_r == ST_START);
  assign out_load = (state_r == ST_OUT) && (!out_valid || !out_stall);
  assign mem_we   = (state_r == ST_WB) && range_r &&
                    ((op_r == OP_START) || (op_r == OP_END));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 8'd3;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_q_r <= mem_r[rd_addr];
    end
    if (mem_we) begin
      mem_r[addr_r] <= upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r     <= in_operation;
      idx_r    <= in_server_index;
      ok_r     <= in_success;
      rt_r     <= in_response_time;
      range_r  <= in_range;
      addr_r   <= rd_addr;
      rd_vld_r <= in_range && vld_r[rd_addr];
    end
  end

  always_comb begin
    cur           = rd_vld_r ? rd_q_r : ENTRY_RST;
    upd_nxt       = cur;
    pool_req_nxt  = pool_req_r;
    pool_fail_nxt = pool_fail_r;
    pool_sum_nxt  = pool_sum_r;
    streak_inc    = (cur.streak == 8'hFF) ? cur.streak : cur.streak + 8'd1;
    if (range_r) begin
      case (op_r)
        OP_START: begin
          upd_nxt.active = (cur.active == 16'hFFFF) ? cur.active : cur.active + 16'd1;
          upd_nxt.req    = sat_inc32(cur.req);
          pool_req_nxt   = sat_inc32(pool_req_r);
        end
        OP_END: begin
          upd_nxt.active = (cur.active == 16'd0) ? cur.active : cur.active - 16'd1;
          upd_nxt.tsum   = sat_add64(cur.tsum, rt_r);
          pool_sum_nxt   = sat_add64(pool_sum_r, rt_r);
          if (!ok_r) begin
            upd_nxt.fails  = sat_inc32(cur.fails);
            pool_fail_nxt  = sat_inc32(pool_fail_r);
            upd_nxt.streak = streak_inc;
            if (streak_inc >= thr_r) begin
              upd_nxt.health = 1'b0;
            end
          end else begin
            upd_nxt.streak = 8'd0;
            upd_nxt.health = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  bht_div u_div_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (upd_r.tsum),
    .divisor  (upd_r.req),
    .res      (avg_res)
  );

  bht_div u_div_pct (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({{(64 - PCT_NUM_W){1'b0}}, pctnum_r}),
    .divisor  (upd_r.req),
    .res      (pct_res)
  );

  bht_div u_div_pool (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pool_sum_r),
    .divisor  (pool_req_r),
    .res      (pool_res)
  );

  always_comb begin
    avg_val      = avg_res.dz ? 32'd0 : (avg_res.ovf ? 32'hFFFF_FFFF : avg_res.quo);
    pool_avg_val = pool_res.dz ? 32'd0 : (pool_res.ovf ? 32'hFFFF_FFFF : pool_res.quo);
    if (pct_res.dz) begin
      pct_val = 7'd0;
    end else if (pct_res.ovf || (pct_res.quo > 32'(PCT_MAX))) begin
      pct_val = PCT_MAX;
    end else begin
      pct_val = pct_res.quo[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_req_r  <= 32'd0;
      pool_fail_r <= 32'd0;
      pool_sum_r  <= 64'd0;
      pool_avg_r  <= 32'd0;
    end else if (state_r == ST_CALC) begin
      pool_req_r  <= pool_req_nxt;
      pool_fail_r <= pool_fail_nxt;
      pool_sum_r  <= pool_sum_nxt;
    end else if ((state_r == ST_DIVW) && pool_res.done) begin
      pool_avg_r <= pool_avg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      upd_r    <= upd_nxt;
      pctnum_r <= PCT_NUM_W'(upd_nxt.fails) * PCT_NUM_W'(PCT_SCALE);
    end else if ((state_r == ST_DIVW) && avg_res.done) begin
      upd_r.avg <= avg_val;
      upd_r.pct <= pct_val;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (range_r && (op_r == OP_END)) begin
          state_nxt = ST_START;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_START: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (avg_res.done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_server_id           <= idx_r;
      out_healthy             <= range_r & upd_r.health;
      out_in_flight           <= range_r ? upd_r.active : 16'd0;
      out_server_avg_time     <= range_r ? upd_r.avg : 32'd0;
      out_server_fail_percent <= range_r ? upd_r.pct : 7'd0;
      out_streak              <= range_r ? upd_r.streak : 8'd0;
      out_pool_avg_time       <= pool_avg_r;
      out_pool_fail_count     <= pool_fail_r;
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    avg_res.done |-> (pct_res.done && pool_res.done))
    else $error("dividers finished out of step");

  a_pct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (upd_r.pct <= PCT_MAX))
    else $error("failure percent above 100 written to table");

  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == ST_CALC))
    else $error("accepted item did not enter the update step");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |=> (state_r == ST_OUT) && !in_stall == 1'b0)
    else $error("table write-back not followed by result step");

endmodule
`default_nettype wire
